// ===== rtl/core/huop_pkg.sv =====
// Shared types, frame constants and the sine table generator for the heading/pose block.
package huop_pkg;

    localparam logic [7:0] HEAD_FIRST_BYTE  = 8'h0D;
    localparam logic [7:0] HEAD_SECOND_BYTE = 8'h0A;
    localparam logic [7:0] TAIL_FIRST_BYTE  = 8'h0A;
    localparam logic [7:0] TAIL_SECOND_BYTE = 8'h0D;

    // centidegrees
    localparam int QUARTER_TURN = 9000;
    localparam int HALF_QUARTER = 4500;
    localparam int FULL_TURN    = 36000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] turns;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_frame;

    typedef struct packed {
        logic [31:0] heading_out;
        logic [31:0] pos_x_out;
        logic [31:0] pos_y_out;
        logic [31:0] comp_x_out;
        logic [31:0] comp_y_out;
        logic        comp_updated;
    } t_result;

    // Quarter-wave sine entry in Q30, Taylor series to x^17, evaluated at elaboration.
    function automatic logic [30:0] qsin_entry(input int k, input int tb);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [65:0] sum;
        x    = (64'(k) * HALF_PI_Q30) >> tb;
        x2   = (x * x) >> 30;
        term = x;
        sum  = 66'(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - 66'(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + 66'(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - 66'(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + 66'(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - 66'(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + 66'(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - 66'(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + 66'(term);
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > $signed(66'(ONE_Q30))) begin
            sum = 66'(ONE_Q30);
        end
        return sum[30:0];
    endfunction

endpackage

// ===== rtl/core/heading_unwrap_offset_pose.sv =====
// A good frame passes through the frame queue and the back pipeline to the master side.
// Throughput: one frame per cycle; the back pipeline stalls as a whole on output backpressure,
// and the 4-entry frame queue lets the front keep taking frames meanwhile, until it fills.
// Frames with a bad header or tail are taken and give no result.
// Reset (synchronous, active low) clears the turn counter, last heading, held compensated
// position, lever arm and all valid flags.
module heading_unwrap_offset_pose
    import huop_pkg::*;
#(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic [19:0]  i_cfg_wdata,  // lever_arm
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // head_first[7:0], head_second[15:8], tail_first[23:16], tail_second[31:24],
    // heading_raw[47:32], pos_x_raw[79:48], pos_y_raw[111:80]
    input  logic [111:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // heading_out[31:0], pos_x_out[63:32], pos_y_out[95:64],
    // comp_x_out[127:96], comp_y_out[159:128]
    output logic [159:0] o_m_tdata,
    output logic [0:0]   o_m_tuser     // comp_updated[0]
);

    logic [19:0] r_lever_arm;
    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    t_frame      front_item;
    t_frame      q_item;
    t_result     result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lever_arm <= '0;
        end else if (i_cfg_wen) begin
            r_lever_arm <= i_cfg_wdata;
        end
    end

    huop_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_head_first  (i_s_tdata[7:0]),
        .i_head_second (i_s_tdata[15:8]),
        .i_tail_first  (i_s_tdata[23:16]),
        .i_tail_second (i_s_tdata[31:24]),
        .i_heading_raw (i_s_tdata[47:32]),
        .i_pos_x_raw   (i_s_tdata[79:48]),
        .i_pos_y_raw   (i_s_tdata[111:80]),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_item        (front_item)
    );

    huop_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    huop_back #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lever_arm (r_lever_arm),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_result    (result)
    );

    assign o_m_tdata = {result.comp_y_out, result.comp_x_out, result.pos_y_out,
                        result.pos_x_out, result.heading_out};
    assign o_m_tuser = result.comp_updated;

endmodule

// ===== rtl/core/huop_front.sv =====
// Front end: frame check, turn counter and last-heading tracking.
module huop_front
    import huop_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_head_first,
    input  logic [7:0]         i_head_second,
    input  logic [7:0]         i_tail_first,
    input  logic [7:0]         i_tail_second,
    input  logic signed [15:0] i_heading_raw,
    input  logic signed [31:0] i_pos_x_raw,
    input  logic signed [31:0] i_pos_y_raw,
    input  logic               i_q_full,
    output logic               o_push,
    output t_frame             o_item
);

    logic signed [15:0] r_last_heading;
    logic signed [15:0] r_turns;
    logic signed [15:0] n_turns;
    logic signed [16:0] diff;
    logic               good;
    logic               xfer;

    assign o_ready = !i_q_full;
    assign xfer    = i_valid && o_ready;
    assign good    = (i_head_first == HEAD_FIRST_BYTE) && (i_head_second == HEAD_SECOND_BYTE) &&
                     (i_tail_first == TAIL_FIRST_BYTE) && (i_tail_second == TAIL_SECOND_BYTE);
    assign diff    = 17'(i_heading_raw) - 17'(r_last_heading);

    always_comb begin
        n_turns = r_turns;
        if (diff > 17'sd9000) begin
            if (r_turns != 16'sh8000) begin
                n_turns = r_turns - 16'sd1;
            end
        end else if (diff < -17'sd9000) begin
            if (r_turns != 16'sh7FFF) begin
                n_turns = r_turns + 16'sd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_heading <= '0;
            r_turns        <= '0;
        end else if (xfer && good) begin
            r_last_heading <= i_heading_raw;
            r_turns        <= n_turns;
        end
    end

    assign o_push         = xfer && good;
    assign o_item.heading = i_heading_raw;
    assign o_item.turns   = n_turns;
    assign o_item.pos_x   = i_pos_x_raw;
    assign o_item.pos_y   = i_pos_y_raw;

endmodule

// ===== rtl/core/huop_fifo.sv =====
// Short frame queue between the front and back ends.
module huop_fifo
    import huop_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_item,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_frame o_item
);

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_frame             r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/core/huop_back.sv =====
// Back end: negated unwrapped heading, negated position and lever-arm compensation pipeline.
module huop_back
    import huop_pkg::*;
#(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [19:0] i_lever_arm,
    input  logic        i_q_valid,
    input  t_frame      i_q_item,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result
);

    localparam int TB    = TRIG_TABLE_BITS;
    localparam int N     = 1 << TB;
    localparam int K_W   = TB + 1;
    localparam int V_W   = TB + 15;
    localparam int M_W   = V_W + 1;
    localparam int SHIFT = V_W + 14;
    localparam int QT_W  = V_W + M_W - SHIFT;
    localparam logic [63:0] RECIP = (64'd1 << SHIFT) / 64'd9000;

    // quarter-wave sine rom, read registered
    logic [30:0] rom [N+1];
    for (genvar g = 0; g <= N; g++) begin : g_rom
        if (g == N) begin : g_top
            assign rom[g] = ONE_Q30[30:0];
        end else begin : g_ent
            assign rom[g] = qsin_entry(g, TB);
        end
    end

    logic adv;

    // stage 1
    logic               r1_v;
    logic signed [15:0] r1_h;
    logic signed [15:0] r1_tc;
    logic [31:0]        r1_nx;
    logic [31:0]        r1_ny;
    logic               r1_rng;
    logic               r1_neg;
    logic [V_W-1:0]     r1_v_arg;
    // stage 2
    logic               r2_v;
    logic signed [15:0] r2_h;
    logic signed [31:0] r2_turn_cd;
    logic [31:0]        r2_nx;
    logic [31:0]        r2_ny;
    logic               r2_rng;
    logic               r2_neg;
    logic [V_W-1:0]     r2_v_arg;
    logic [QT_W-1:0]    r2_q;
    // stage 3
    logic               r3_v;
    logic [31:0]        r3_hout;
    logic [31:0]        r3_nx;
    logic [31:0]        r3_ny;
    logic               r3_rng;
    logic               r3_neg;
    logic [K_W-1:0]     r3_k;
    // stage 4
    logic               r4_v;
    logic [31:0]        r4_hout;
    logic [31:0]        r4_nx;
    logic [31:0]        r4_ny;
    logic               r4_rng;
    logic               r4_neg;
    logic [30:0]        r4_qs;
    logic [30:0]        r4_qc;
    // stage 5
    logic               r5_v;
    logic [31:0]        r5_hout;
    logic [31:0]        r5_nx;
    logic [31:0]        r5_ny;
    logic               r5_rng;
    logic               r5_neg;
    logic [20:0]        r5_ls;
    logic [20:0]        r5_lc;
    // output and held compensation
    logic               r_out_v;
    t_result            r_out;
    logic [31:0]        r_held_x;
    logic [31:0]        r_held_y;

    logic [15:0]         abs_h;
    logic                in_rng;
    logic [V_W+M_W-1:0]  recip_prod;
    logic [V_W+13:0]     q_times;
    logic [V_W+13:0]     rem;
    logic [QT_W-1:0]     k_fix;
    logic [K_W-1:0]      k_cl;
    logic signed [32:0]  h_sum;
    logic [50:0]         prod_s;
    logic [50:0]         prod_c;
    logic [50:0]         rnd_s;
    logic [50:0]         rnd_c;
    logic signed [33:0]  sum_x;
    logic signed [33:0]  sum_y;
    logic [31:0]         new_x;
    logic [31:0]         new_y;

    function automatic logic [31:0] neg_sat(input logic [31:0] v);
        if (v == 32'h8000_0000) begin
            return 32'h7FFF_FFFF;
        end
        return 32'(-$signed(v));
    endfunction

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end
        if (v < -34'sh0_8000_0000) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    assign adv     = !r_out_v || i_ready;
    assign o_q_pop = adv && i_q_valid;

    assign in_rng = (i_q_item.heading >= -16'sd9000) && (i_q_item.heading < 16'sd9000);
    assign abs_h  = i_q_item.heading[15] ? 16'(-i_q_item.heading) : i_q_item.heading;

    // k = round(|h| * N / 9000) via reciprocal, then one correction step
    assign recip_prod = (V_W+M_W)'(r1_v_arg) * (V_W+M_W)'(RECIP[M_W-1:0]);
    assign q_times    = (V_W+14)'(r2_q) * (V_W+14)'(QUARTER_TURN);
    assign rem        = (V_W+14)'(r2_v_arg) - q_times;
    assign k_fix      = (rem >= (V_W+14)'(QUARTER_TURN)) ? r2_q + QT_W'(1) : r2_q;
    assign k_cl       = (k_fix > QT_W'(N)) ? K_W'(N) : k_fix[K_W-1:0];
    assign h_sum      = 33'(r2_h) + 33'(r2_turn_cd);

    assign prod_s = 51'(i_lever_arm) * 51'(r4_qs);
    assign prod_c = 51'(i_lever_arm) * 51'(r4_qc);
    assign rnd_s  = prod_s + (51'd1 << 29);
    assign rnd_c  = prod_c + (51'd1 << 29);

    assign sum_x = 34'($signed(r5_nx)) + (r5_neg ? -34'(r5_ls) : 34'(r5_ls));
    assign sum_y = 34'($signed(r5_ny)) + 34'(r5_lc) - 34'(i_lever_arm);
    assign new_x = sat32(sum_x);
    assign new_y = sat32(sum_y);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_h     <= i_q_item.heading;
            r1_tc    <= i_q_item.turns;
            r1_nx    <= neg_sat(i_q_item.pos_x);
            r1_ny    <= neg_sat(i_q_item.pos_y);
            r1_rng   <= in_rng;
            r1_neg   <= i_q_item.heading[15];
            r1_v_arg <= (V_W'(abs_h[13:0]) << TB) + V_W'(HALF_QUARTER);

            r2_h       <= r1_h;
            r2_turn_cd <= 32'(r1_tc) * 32'sd36000;
            r2_nx      <= r1_nx;
            r2_ny      <= r1_ny;
            r2_rng     <= r1_rng;
            r2_neg     <= r1_neg;
            r2_v_arg   <= r1_v_arg;
            r2_q       <= recip_prod[V_W+M_W-1:SHIFT];

            r3_hout <= 32'(-h_sum);
            r3_nx   <= r2_nx;
            r3_ny   <= r2_ny;
            r3_rng  <= r2_rng;
            r3_neg  <= r2_neg;
            r3_k    <= k_cl;

            r4_hout <= r3_hout;
            r4_nx   <= r3_nx;
            r4_ny   <= r3_ny;
            r4_rng  <= r3_rng;
            r4_neg  <= r3_neg;
            r4_qs   <= rom[r3_k];
            r4_qc   <= rom[K_W'(N) - r3_k];

            r5_hout <= r4_hout;
            r5_nx   <= r4_nx;
            r5_ny   <= r4_ny;
            r5_rng  <= r4_rng;
            r5_neg  <= r4_neg;
            r5_ls   <= rnd_s[50:30];
            r5_lc   <= rnd_c[50:30];

            r_out.heading_out  <= r5_hout;
            r_out.pos_x_out    <= r5_nx;
            r_out.pos_y_out    <= r5_ny;
            r_out.comp_x_out   <= r5_rng ? new_x : r_held_x;
            r_out.comp_y_out   <= r5_rng ? new_y : r_held_y;
            r_out.comp_updated <= r5_rng;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r4_v     <= 1'b0;
            r5_v     <= 1'b0;
            r_out_v  <= 1'b0;
            r_held_x <= '0;
            r_held_y <= '0;
        end else if (adv) begin
            r1_v    <= i_q_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            r_out_v <= r5_v;
            if (r5_v && r5_rng) begin
                r_held_x <= new_x;
                r_held_y <= new_y;
            end
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule
